// ===== rtl/hps_pkg.sv =====
// hps_pkg: shared constants, register codes and structs of the heat plate stencil core
// no dependencies
`timescale 1ns / 1ps

package hps_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int LEN_W  = 11;
    localparam int VAL_W  = 15;
    localparam int WORD_W = VAL_W + 1;
    localparam int HOT_W  = 21;
    localparam int DIFF_W = 17;
    localparam int SUM_W  = VAL_W + 3;
    localparam int CFG_W  = 17;
    localparam int ADDR_W = 2;

    localparam logic [HOT_W-1:0] HOT_MAX = {HOT_W{1'b1}};

    // register indexes of the configuration port
    typedef enum logic [ADDR_W-1:0] {
        CFG_MODE          = 2'd0,
        CFG_ROW_LENGTH    = 2'd1,
        CFG_EPSILON_X4    = 2'd2,
        CFG_HOT_THRESHOLD = 2'd3
    } cfg_reg_t;

    localparam logic MODE_SWEEP = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    localparam logic [LEN_W-1:0]  ROW_LENGTH_RST    = LEN_W'(MAX_COLUMNS);
    localparam logic [DIFF_W-1:0] EPSILON_X4_RST    = DIFF_W'(102);
    localparam logic [VAL_W-1:0]  HOT_THRESHOLD_RST = VAL_W'(12800);

    // line store access for one beat
    typedef struct packed {
        logic              rd_wr_en;
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  col_right;
        logic [WORD_W-1:0] wdata;
        logic              up_wr_en;
        logic [COL_W-1:0]  up_col;
    } store_req_t;

    // cell in flight between the input side and the stencil stage
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [COL_W-1:0] col;
        logic             row0;
        logic             interior;
        logic             frame_end;
    } item_t;

    // frame summary reported on the last cell
    typedef struct packed {
        logic              valid;
        logic [HOT_W-1:0]  hot_count;
        logic [DIFF_W-1:0] max_diff_x4;
        logic              not_steady;
    } summary_t;

endpackage

// ===== rtl/hps_line_store.sv =====
// hps_line_store: middle and upper row memories with registered read data
// depends on hps_pkg
`timescale 1ns / 1ps

module hps_line_store (
    input  logic                      aclk,
    input  hps_pkg::store_req_t       req,
    output logic [hps_pkg::WORD_W-1:0] centre_word,
    output logic [hps_pkg::WORD_W-1:0] right_word,
    output logic [hps_pkg::WORD_W-1:0] up_word
);
    import hps_pkg::*;

    logic [WORD_W-1:0] mid_mem [MAX_COLUMNS];
    logic [WORD_W-1:0] up_mem  [MAX_COLUMNS];

    logic [WORD_W-1:0] mid_c_reg;
    logic [WORD_W-1:0] mid_r_reg;
    logic [WORD_W-1:0] up_c_reg;

    // middle row: two reads and the new cell written on each beat
    always_ff @(posedge aclk) begin
        if (req.rd_wr_en) begin
            mid_c_reg         <= mid_mem[req.col];
            mid_r_reg         <= mid_mem[req.col_right];
            mid_mem[req.col]  <= req.wdata;
        end
    end

    // upper row: old centre moves up when the cell leaves the stencil stage
    always_ff @(posedge aclk) begin
        if (req.rd_wr_en) begin
            up_c_reg <= up_mem[req.col];
        end
        if (req.up_wr_en) begin
            up_mem[req.up_col] <= mid_c_reg;
        end
    end

    assign centre_word = mid_c_reg;
    assign right_word  = mid_r_reg;
    assign up_word     = up_c_reg;

endmodule

// ===== rtl/hps_stencil_calc.sv =====
// hps_stencil_calc: five point update, deviation and hot tracking for one cell
// depends on hps_pkg
`timescale 1ns / 1ps

module hps_stencil_calc (
    input  hps_pkg::item_t              item,
    input  logic                        mode,
    input  logic [hps_pkg::DIFF_W-1:0]  epsilon_x4,
    input  logic [hps_pkg::VAL_W-1:0]   hot_threshold,
    input  logic [hps_pkg::WORD_W-1:0]  centre_word,
    input  logic [hps_pkg::WORD_W-1:0]  up_word,
    input  logic [hps_pkg::WORD_W-1:0]  right_word,
    input  logic [hps_pkg::WORD_W-1:0]  left_word,
    input  logic [hps_pkg::HOT_W-1:0]   hot_in,
    input  logic [hps_pkg::DIFF_W-1:0]  max_in,
    output logic [hps_pkg::VAL_W-1:0]   cell_out,
    output logic [hps_pkg::HOT_W-1:0]   hot_out,
    output logic [hps_pkg::DIFF_W-1:0]  max_out,
    output hps_pkg::summary_t           summary
);
    import hps_pkg::*;

    logic [VAL_W-1:0]  centre;
    logic              active;
    logic [DIFF_W-1:0] nb_sum;
    logic [DIFF_W-1:0] c4;
    logic [SUM_W-1:0]  total;
    logic [DIFF_W-1:0] diff;

    always_comb begin
        centre = centre_word[VAL_W-1:0];
        active = !item.row0 && item.interior && !centre_word[VAL_W];
        nb_sum = DIFF_W'(up_word[VAL_W-1:0]) + DIFF_W'(item.value)
               + DIFF_W'(left_word[VAL_W-1:0]) + DIFF_W'(right_word[VAL_W-1:0]);
        c4     = {centre, 2'b00};
        total  = SUM_W'(nb_sum) + SUM_W'(c4);
        diff   = (c4 >= nb_sum) ? (c4 - nb_sum) : (nb_sum - c4);

        if (item.row0) begin
            cell_out = item.value;
        end else if (active && mode == MODE_SWEEP) begin
            cell_out = total[SUM_W-1:3];
        end else begin
            cell_out = centre;
        end

        hot_out = hot_in;
        max_out = max_in;
        if (active && mode == MODE_CHECK) begin
            if (centre > hot_threshold && hot_in != HOT_MAX) begin
                hot_out = hot_in + HOT_W'(1);
            end
            if (diff > max_in) begin
                max_out = diff;
            end
        end

        summary = '0;
        if (item.frame_end && mode == MODE_CHECK) begin
            summary.valid       = 1'b1;
            summary.hot_count   = hot_out;
            summary.max_diff_x4 = max_out;
            summary.not_steady  = (max_out > epsilon_x4);
        end
    end

endmodule

// ===== rtl/heat_plate_stencil_sweep_core.sv =====
// heat_plate_stencil_sweep_core: streaming five point heat stencil with line stores
// depends on hps_pkg, hps_line_store, hps_stencil_calc
`timescale 1ns / 1ps

// Takes a heat plate one cell per beat in raster order and returns one beat per
// cell, for the cell one row up (row 0 comes straight back). A beat can be
// taken on every clock while the output is not stalled. The edge that takes a
// cell also loads the synchronous read of the line stores and puts the cell in
// the stencil stage; once the output register is free, a later edge loads the
// stencil arithmetic into the output register. The stencil stage holds one cell
// behind a waiting result, so one more cell is taken while the output stalls and
// then the input stalls as well until the result leaves.
// The line stores have no reset and need no clearing pass: the first rows of a
// frame fill them before anything reads them. Mode 0 updates unlocked interior
// cells as (four neighbours + 4*centre)>>3; mode 1 passes cells through and
// reports hot count, largest deviation and not-steady on the frame-end beat.
// Configuration writes belong to idle periods only.

module heat_plate_stencil_sweep_core (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic                        cfg_wr_en,
    input  logic [hps_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [hps_pkg::CFG_W-1:0]   cfg_wr_data,
    // input cells
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // cell_value[14:0], locked[15]
    input  logic        s_axis_tlast,   // frame_end
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // cell_out[14:0], hot_count[35:15],
                                        // max_diff_x4[52:36], not_steady[53], zero[55:54]
    output logic        m_axis_tuser    // summary_valid
);
    import hps_pkg::*;

    // configuration registers
    logic              mode_reg;
    logic [LEN_W-1:0]  row_length_reg;
    logic [DIFF_W-1:0] epsilon_x4_reg;
    logic [VAL_W-1:0]  hot_threshold_reg;

    // raster position
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    // stencil stage
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [WORD_W-1:0] left_reg;

    // frame statistics
    logic [HOT_W-1:0]  hot_reg, hot_next;
    logic [DIFF_W-1:0] max_reg, max_next;

    // output register
    logic              m_valid_reg;
    logic [VAL_W-1:0]  cell_out_reg;
    summary_t          summary_reg;

    logic              in_beat;
    logic              s1_adv;
    logic [LEN_W-1:0]  len;
    logic [COL_W-1:0]  col;
    logic [LEN_W-1:0]  col_inc;
    logic              last_col;
    item_t             item_in;
    store_req_t        store_req;

    logic [WORD_W-1:0] centre_word;
    logic [WORD_W-1:0] right_word;
    logic [WORD_W-1:0] up_word;
    logic [VAL_W-1:0]  calc_cell;
    logic [HOT_W-1:0]  calc_hot;
    logic [DIFF_W-1:0] calc_max;
    summary_t          calc_summary;

    // handshake: stencil stage moves on when the output register is free
    assign s1_adv        = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_SWEEP;
            row_length_reg    <= ROW_LENGTH_RST;
            epsilon_x4_reg    <= EPSILON_X4_RST;
            hot_threshold_reg <= HOT_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MODE:          mode_reg          <= cfg_wr_data[0];
                CFG_ROW_LENGTH:    row_length_reg    <= cfg_wr_data[LEN_W-1:0];
                CFG_EPSILON_X4:    epsilon_x4_reg    <= cfg_wr_data[DIFF_W-1:0];
                CFG_HOT_THRESHOLD: hot_threshold_reg <= cfg_wr_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // row length clamped to the usable range, column clamped to the last column
    always_comb begin
        if (row_length_reg < LEN_W'(3)) begin
            len = LEN_W'(3);
        end else if (row_length_reg > LEN_W'(MAX_COLUMNS)) begin
            len = LEN_W'(MAX_COLUMNS);
        end else begin
            len = row_length_reg;
        end

        if (LEN_W'(col_reg) > len - LEN_W'(1)) begin
            col = COL_W'(len - LEN_W'(1));
        end else begin
            col = col_reg;
        end
        col_inc  = LEN_W'(col) + LEN_W'(1);
        last_col = (col_inc >= len);

        item_in.value     = s_axis_tdata[VAL_W-1:0];
        item_in.col       = col;
        item_in.row0      = (row_reg == '0);
        item_in.interior  = (row_reg >= ROW_W'(2)) && (col != '0) && !last_col;
        item_in.frame_end = s_axis_tlast;

        // raster advance
        col_next = col_reg;
        row_next = row_reg;
        if (in_beat) begin
            if (s_axis_tlast) begin
                col_next = '0;
                row_next = '0;
            end else if (last_col) begin
                col_next = '0;
                if (row_reg != ROW_W'(MAX_ROWS - 1)) begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store access: reads and new cell on the input beat, upper row on advance
    always_comb begin
        store_req.rd_wr_en  = in_beat;
        store_req.col       = col;
        store_req.col_right = col_inc[COL_W-1:0];
        store_req.wdata     = s_axis_tdata[WORD_W-1:0];
        store_req.up_wr_en  = s1_adv;
        store_req.up_col    = s1_item_reg.col;
    end

    hps_line_store u_line_store (
        .aclk        (aclk),
        .req         (store_req),
        .centre_word (centre_word),
        .right_word  (right_word),
        .up_word     (up_word)
    );

    // stencil stage holds the cell while its store words are read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_beat) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            s1_item_reg <= item_in;
        end
        // left neighbour is the centre of the previous cell in the row
        if (s1_adv) begin
            left_reg <= centre_word;
        end
    end

    hps_stencil_calc u_calc (
        .item          (s1_item_reg),
        .mode          (mode_reg),
        .epsilon_x4    (epsilon_x4_reg),
        .hot_threshold (hot_threshold_reg),
        .centre_word   (centre_word),
        .up_word       (up_word),
        .right_word    (right_word),
        .left_word     (left_reg),
        .hot_in        (hot_reg),
        .max_in        (max_reg),
        .cell_out      (calc_cell),
        .hot_out       (calc_hot),
        .max_out       (calc_max),
        .summary       (calc_summary)
    );

    // frame statistics clear after the frame-end cell
    always_comb begin
        hot_next = hot_reg;
        max_next = max_reg;
        if (s1_adv) begin
            if (s1_item_reg.frame_end) begin
                hot_next = '0;
                max_next = '0;
            end else begin
                hot_next = calc_hot;
                max_next = calc_max;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hot_reg <= '0;
            max_reg <= '0;
        end else begin
            hot_reg <= hot_next;
            max_reg <= max_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            cell_out_reg <= calc_cell;
            summary_reg  <= calc_summary;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = summary_reg.valid;
    assign m_axis_tdata  = {2'b00, summary_reg.not_steady, summary_reg.max_diff_x4,
                            summary_reg.hot_count, cell_out_reg};

    // summary fields stay zero on ordinary beats
    a_summary_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[53:15] == '0))
        else $error("summary fields set without summary_valid");

    // not steady needs a nonzero deviation
    a_not_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[53]) |-> (m_axis_tdata[52:36] != '0))
        else $error("not_steady with zero deviation");

    // a stalled stencil stage keeps its cell
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stencil stage dropped a cell");

    // a stalled result is never overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |-> !s1_adv)
        else $error("output register overwritten while stalled");

endmodule
